### design/world_matrix_builder_core_macros.svh
// Assertion macros for the world matrix builder.
// Used by world_matrix_builder_core; expects clk and arst_n in scope.
`ifndef WORLD_MATRIX_BUILDER_CORE_MACROS_SVH
`define WORLD_MATRIX_BUILDER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define WMB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define WMB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/wmb_pkg.sv
// Types and fixed-point constants for the world matrix builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wmb_pkg;
	typedef logic signed [31:0] q16_t;
	typedef logic signed [15:0] angle_t;
	typedef logic signed [15:0] q14_t;
	typedef logic [1:0] row_t;

	localparam int unsigned ATAN_LEN = 24;

	localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
	localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
	localparam q16_t Q16_ONE = 32'sd65536;

	localparam row_t ROW_0 = 2'd0;
	localparam row_t ROW_1 = 2'd1;
	localparam row_t ROW_2 = 2'd2;
	localparam row_t ROW_3 = 2'd3;

	localparam logic signed [31:0] ATAN_Q30 [ATAN_LEN] = '{
		32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
		32'sd67021686, 32'sd33543515, 32'sd16775850, 32'sd8388437,
		32'sd4194282, 32'sd2097149, 32'sd1048575, 32'sd524287,
		32'sd262143, 32'sd131071, 32'sd65535, 32'sd32767,
		32'sd16383, 32'sd8191, 32'sd4095, 32'sd2047,
		32'sd1023, 32'sd511, 32'sd255, 32'sd127
	};
endpackage
`default_nettype wire

### design/wmb_item_if.sv
// Input and result channels of the world matrix builder.
// Depends on wmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface wmb_item_if;
	logic valid;
	logic ready;
	wmb_pkg::q16_t translate_x;
	wmb_pkg::q16_t translate_y;
	wmb_pkg::q16_t translate_z;
	wmb_pkg::angle_t angle_x;
	wmb_pkg::angle_t angle_y;
	wmb_pkg::angle_t angle_z;
	wmb_pkg::q16_t scale_x;
	wmb_pkg::q16_t scale_y;
	wmb_pkg::q16_t scale_z;

	modport source (output valid, translate_x, translate_y, translate_z, angle_x, angle_y,
		angle_z, scale_x, scale_y, scale_z, input ready);
	modport sink (input valid, translate_x, translate_y, translate_z, angle_x, angle_y,
		angle_z, scale_x, scale_y, scale_z, output ready);
endinterface

interface wmb_row_if;
	logic valid;
	logic ready;
	wmb_pkg::row_t row_index;
	wmb_pkg::q16_t col0;
	wmb_pkg::q16_t col1;
	wmb_pkg::q16_t col2;
	wmb_pkg::q16_t col3;
	logic last_row;

	modport source (output valid, row_index, col0, col1, col2, col3, last_row, input ready);
	modport sink (input valid, row_index, col0, col1, col2, col3, last_row, output ready);
endinterface
`default_nettype wire

### design/wmb_cordic.sv
// Pipelined sine/cosine: range reduction, one CORDIC step per stage, Q1.14 rounding.
// Depends on wmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wmb_cordic #(
	parameter int unsigned STEPS = 14
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire wmb_pkg::angle_t angle,
	output wmb_pkg::q14_t        sin_q14,
	output wmb_pkg::q14_t        cos_q14
);
	import wmb_pkg::*;

	logic signed [34:0] z_w;
	logic signed [34:0] z_s1;
	logic signed [33:0] z_s2;
	logic               neg_s2;
	logic signed [33:0] x_in [STEPS];
	logic signed [33:0] y_in [STEPS];
	logic signed [33:0] z_in [STEPS];
	logic               n_in [STEPS];
	logic signed [33:0] x_s [STEPS];
	logic signed [33:0] y_s [STEPS];
	logic signed [33:0] z_s [STEPS];
	logic               neg_s [STEPS];
	logic signed [17:0] cr;
	logic signed [17:0] sr;

	assign z_w = 35'(angle) <<< 18;

	// wrap into [-pi, pi]
	always_ff @(posedge clk) begin
		if (en) begin
			if (z_w > Q30_PI) begin
				z_s1 <= z_w - Q30_TWO_PI;
			end else if (z_w < -Q30_PI) begin
				z_s1 <= z_w + Q30_TWO_PI;
			end else begin
				z_s1 <= z_w;
			end
		end
	end

	// fold into [-pi/2, pi/2], negate the results later
	always_ff @(posedge clk) begin
		if (en) begin
			if (z_s1 > Q30_HALF_PI) begin
				z_s2   <= 34'(z_s1 - Q30_PI);
				neg_s2 <= 1'b1;
			end else if (z_s1 < -Q30_HALF_PI) begin
				z_s2   <= 34'(z_s1 + Q30_PI);
				neg_s2 <= 1'b1;
			end else begin
				z_s2   <= 34'(z_s1);
				neg_s2 <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		if (i == 0) begin : g_first
			assign x_in[i] = Q30_GAIN;
			assign y_in[i] = '0;
			assign z_in[i] = z_s2;
			assign n_in[i] = neg_s2;
		end else begin : g_next
			assign x_in[i] = x_s[i-1];
			assign y_in[i] = y_s[i-1];
			assign z_in[i] = z_s[i-1];
			assign n_in[i] = neg_s[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[i] <= n_in[i];
				if (!z_in[i][33]) begin
					x_s[i] <= x_in[i] - (y_in[i] >>> i);
					y_s[i] <= y_in[i] + (x_in[i] >>> i);
					z_s[i] <= z_in[i] - 34'(ATAN_Q30[i]);
				end else begin
					x_s[i] <= x_in[i] + (y_in[i] >>> i);
					y_s[i] <= y_in[i] - (x_in[i] >>> i);
					z_s[i] <= z_in[i] + 34'(ATAN_Q30[i]);
				end
			end
		end
	end

	function automatic q14_t to_q14(input logic signed [33:0] v, input logic neg);
		logic signed [34:0] t;
		logic signed [17:0] r;
		t = 35'(v) + 35'sd32768;
		r = 18'(t >>> 16);
		if (r > 18'sd16384) begin
			r = 18'sd16384;
		end else if (r < -18'sd16384) begin
			r = -18'sd16384;
		end
		if (neg) begin
			r = -r;
		end
		return 16'(r);
	endfunction

	assign cr = 18'(to_q14(x_s[STEPS-1], neg_s[STEPS-1]));
	assign sr = 18'(to_q14(y_s[STEPS-1], neg_s[STEPS-1]));

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q14 <= 16'(cr);
			sin_q14 <= 16'(sr);
		end
	end
endmodule
`default_nettype wire

### design/world_matrix_builder_core.sv
// Channel   | Dir | Carries
// req       | in  | translation, three angles, three scales (one transfer per matrix)
// rsp       | out | one matrix row per transfer, rows 0..3, last_row on row 3
//
// Sustained throughput is bounded by the rsp channel, which the four rows of a matrix share.
// The pipeline takes a new item each cycle while its oldest item can move on; when
// that item waits for the row serializer, every stage holds. Reset clears only
// valid and row state.
// Depends on wmb_pkg, wmb_item_if, wmb_row_if, wmb_cordic and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "world_matrix_builder_core_macros.svh"
module world_matrix_builder_core #(
	parameter int unsigned TRIG_STEPS = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	wmb_item_if.sink   req,
	wmb_row_if.source  rsp
);
	import wmb_pkg::*;

	localparam int unsigned CL    = TRIG_STEPS + 3;
	localparam int unsigned DEPTH = CL + 5;

	logic             vld_q [DEPTH];
	logic             adv;
	logic             ser_take;
	logic             load;
	logic             busy_q;
	row_t             row_q;

	q14_t sx, cx, sy, cy, sz, cz;

	q16_t tx_s [CL];
	q16_t ty_s [CL];
	q16_t tz_s [CL];
	q16_t kx_s [CL];
	q16_t ky_s [CL];
	q16_t kz_s [CL];

	// pair products
	logic signed [31:0] cycz_s2, cysz_s2, cxsz_s2, cxcz_s2, sxcy_s2;
	logic signed [31:0] cxcy_s2, sxsy_s2, cxsy_s2, sxsz_s2, sxcz_s2;
	q14_t sy_s2;
	q16_t t_s2 [3];
	q16_t k_s2 [3];
	// cz and sz one stage later, to meet sxsy and cxsy
	q14_t cz_d2, sz_d2;
	// triple products
	logic signed [47:0] sxsycz_s3, sxsysz_s3, cxsycz_s3, cxsysz_s3;
	logic signed [31:0] cycz_s3, cysz_s3, cxsz_s3, cxcz_s3, sxcy_s3;
	logic signed [31:0] cxcy_s3, sxsz_s3, sxcz_s3;
	q14_t sy_s3;
	q16_t t_s3 [3];
	q16_t k_s3 [3];
	// rotation entries in Q42, rounded to Q30
	logic signed [45:0] r42 [9];
	logic signed [32:0] r30_s4 [9];
	q16_t t_s4 [3];
	q16_t k_s4 [3];
	logic signed [64:0] p_s5 [9];
	q16_t t_s5 [3];
	q16_t e_s6 [9];
	q16_t t_s6 [3];
	q16_t e_q [9];
	q16_t t_q [3];

	assign ser_take = !busy_q || (rsp.ready && row_q == ROW_3);
	assign adv      = !vld_q[DEPTH-1] || ser_take;
	assign load     = ser_take && vld_q[DEPTH-1];
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= req.valid;
			for (int i = 1; i < DEPTH; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	wmb_cordic #(.STEPS(TRIG_STEPS)) u_cordic_x (
		.clk(clk), .en(adv), .angle(req.angle_x), .sin_q14(sx), .cos_q14(cx));
	wmb_cordic #(.STEPS(TRIG_STEPS)) u_cordic_y (
		.clk(clk), .en(adv), .angle(req.angle_y), .sin_q14(sy), .cos_q14(cy));
	wmb_cordic #(.STEPS(TRIG_STEPS)) u_cordic_z (
		.clk(clk), .en(adv), .angle(req.angle_z), .sin_q14(sz), .cos_q14(cz));

	// carry translation and scale alongside the trig pipeline
	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s[0] <= req.translate_x;
			ty_s[0] <= req.translate_y;
			tz_s[0] <= req.translate_z;
			kx_s[0] <= req.scale_x;
			ky_s[0] <= req.scale_y;
			kz_s[0] <= req.scale_z;
			for (int i = 1; i < CL; i++) begin
				tx_s[i] <= tx_s[i-1];
				ty_s[i] <= ty_s[i-1];
				tz_s[i] <= tz_s[i-1];
				kx_s[i] <= kx_s[i-1];
				ky_s[i] <= ky_s[i-1];
				kz_s[i] <= kz_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cycz_s2 <= cy * cz;
			cysz_s2 <= cy * sz;
			cxsz_s2 <= cx * sz;
			cxcz_s2 <= cx * cz;
			sxcy_s2 <= sx * cy;
			cxcy_s2 <= cx * cy;
			sxsy_s2 <= sx * sy;
			cxsy_s2 <= cx * sy;
			sxsz_s2 <= sx * sz;
			sxcz_s2 <= sx * cz;
			sy_s2   <= sy;
			t_s2    <= '{tx_s[CL-1], ty_s[CL-1], tz_s[CL-1]};
			k_s2    <= '{kx_s[CL-1], ky_s[CL-1], kz_s[CL-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cz_d2 <= cz;
			sz_d2 <= sz;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sxsycz_s3 <= 48'(sxsy_s2) * 48'(cz_d2);
			sxsysz_s3 <= 48'(sxsy_s2) * 48'(sz_d2);
			cxsycz_s3 <= 48'(cxsy_s2) * 48'(cz_d2);
			cxsysz_s3 <= 48'(cxsy_s2) * 48'(sz_d2);
			cycz_s3   <= cycz_s2;
			cysz_s3   <= cysz_s2;
			cxsz_s3   <= cxsz_s2;
			cxcz_s3   <= cxcz_s2;
			sxcy_s3   <= sxcy_s2;
			cxcy_s3   <= cxcy_s2;
			sxsz_s3   <= sxsz_s2;
			sxcz_s3   <= sxcz_s2;
			sy_s3     <= sy_s2;
			t_s3      <= t_s2;
			k_s3      <= k_s2;
		end
	end

	always_comb begin
		r42[0] = 46'(cycz_s3) <<< 14;
		r42[1] = 46'(cysz_s3) <<< 14;
		r42[2] = -(46'(sy_s3) <<< 28);
		r42[3] = -(46'(cxsz_s3) <<< 14) + 46'(sxsycz_s3);
		r42[4] = (46'(cxcz_s3) <<< 14) + 46'(sxsysz_s3);
		r42[5] = 46'(sxcy_s3) <<< 14;
		r42[6] = (46'(sxsz_s3) <<< 14) + 46'(cxsycz_s3);
		r42[7] = -(46'(sxcz_s3) <<< 14) + 46'(cxsysz_s3);
		r42[8] = 46'(cxcy_s3) <<< 14;
	end

	function automatic logic signed [32:0] rnd12(input logic signed [45:0] r);
		logic signed [46:0] t;
		t = 47'(r) + 47'sd2048;
		return 33'(t >>> 12);
	endfunction

	function automatic q16_t rnd_sat(input logic signed [64:0] p);
		logic signed [65:0] t;
		logic signed [35:0] v;
		t = 66'(p) + 66'sd536870912;
		v = 36'(t >>> 30);
		if (v > 36'sd2147483647) begin
			v = 36'sd2147483647;
		end else if (v < -36'sd2147483648) begin
			v = -36'sd2147483648;
		end
		return 32'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				r30_s4[i] <= rnd12(r42[i]);
			end
			t_s4 <= t_s3;
			k_s4 <= k_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				p_s5[i] <= 65'(r30_s4[i]) * 65'(k_s4[i % 3]);
			end
			t_s5 <= t_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				e_s6[i] <= rnd_sat(p_s5[i]);
			end
			t_s6 <= t_s5;
		end
	end

	// row serializer: hold one matrix, hand out a row per transfer
	always_ff @(posedge clk) begin
		if (load) begin
			e_q <= e_s6;
			t_q <= t_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= ROW_0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= ROW_0;
		end else if (busy_q && rsp.ready) begin
			if (row_q == ROW_3) begin
				busy_q <= 1'b0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	assign rsp.valid     = busy_q;
	assign rsp.row_index = row_q;
	assign rsp.last_row  = (row_q == ROW_3);

	always_comb begin
		case (row_q)
			ROW_0: begin
				rsp.col0 = e_q[0];
				rsp.col1 = e_q[1];
				rsp.col2 = e_q[2];
				rsp.col3 = t_q[0];
			end
			ROW_1: begin
				rsp.col0 = e_q[3];
				rsp.col1 = e_q[4];
				rsp.col2 = e_q[5];
				rsp.col3 = t_q[1];
			end
			ROW_2: begin
				rsp.col0 = e_q[6];
				rsp.col1 = e_q[7];
				rsp.col2 = e_q[8];
				rsp.col3 = t_q[2];
			end
			default: begin
				rsp.col0 = '0;
				rsp.col1 = '0;
				rsp.col2 = '0;
				rsp.col3 = Q16_ONE;
			end
		endcase
	end

	`WMB_ASSERT_NEXT(a_row_advance, busy_q && rsp.ready && row_q != ROW_3 && !load, busy_q && row_q == $past(row_q) + 2'd1, "row did not advance after transfer")
	`WMB_ASSERT_NOW(a_no_early_load, busy_q && row_q != ROW_3, !load, "matrix loaded before last row left")
	`WMB_ASSERT_NEXT(a_tail_hold, vld_q[DEPTH-1] && !ser_take, vld_q[DEPTH-1], "pipeline tail dropped while stalled")
	`WMB_ASSERT_NEXT(a_load_row0, load, busy_q && row_q == ROW_0, "new matrix did not start at row 0")
endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for world_matrix_builder_core: drives matrix requests,
// predicts the four rows of each world matrix and compares every row transfer.
// Depends on wmb_pkg, wmb_item_if, wmb_row_if and the core.
`timescale 1ns / 1ps
module tb;
	import wmb_pkg::*;

	localparam int unsigned STEPS = 14;
	localparam int unsigned LATENCY = STEPS + 9;

	typedef struct packed {
		q16_t tx, ty, tz;
		angle_t ax, ay, az;
		q16_t sx, sy, sz;
	} matrix_req_t;

	typedef struct packed {
		row_t idx;
		q16_t c0, c1, c2, c3;
		logic last;
	} matrix_row_t;

	logic clk;
	logic arst_n;
	logic failed;
	logic hold_rsp;

	wmb_item_if req ();
	wmb_row_if rsp ();

	world_matrix_builder_core #(.TRIG_STEPS(STEPS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	matrix_req_t pending_reqs[$];
	matrix_row_t expected_rows[$];

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint round_q14(longint v);
		longint r;
		r = floor_shr(v + 64'sd32768, 16);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r;
	endfunction

	task automatic sin_cos_q14(input angle_t ang, output longint s, output longint c);
		longint z, x, y, nx, at;
		bit neg;
		z = longint'(ang) * 64'sd262144;
		x = Q30_GAIN;
		y = 0;
		neg = 0;
		while (z > Q30_PI)
			z -= Q30_TWO_PI;
		while (z < -longint'(Q30_PI))
			z += Q30_TWO_PI;
		if (z > Q30_HALF_PI) begin
			z -= Q30_PI;
			neg = 1;
		end else if (z < -longint'(Q30_HALF_PI)) begin
			z += Q30_PI;
			neg = 1;
		end
		for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
			at = ATAN_Q30[i];
			if (z >= 0) begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= at;
			end else begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += at;
			end
			x = nx;
		end
		c = round_q14(x);
		s = round_q14(y);
		if (neg) begin
			c = -c;
			s = -s;
		end
	endtask

	function automatic q16_t scale_entry(longint r42, q16_t scale);
		longint r30, v;
		r30 = floor_shr(r42 + 64'sd2048, 12);
		v = floor_shr(r30 * longint'(scale) + 64'sd536870912, 30);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return q16_t'(v);
	endfunction

	task automatic predict_matrix(input matrix_req_t m);
		longint sx, cx, sy, cy, sz, cz;
		longint r[3][3];
		q16_t sc[3];
		q16_t t[3];
		matrix_row_t row;
		sin_cos_q14(m.ax, sx, cx);
		sin_cos_q14(m.ay, sy, cy);
		sin_cos_q14(m.az, sz, cz);
		sc = '{m.sx, m.sy, m.sz};
		t = '{m.tx, m.ty, m.tz};
		r[0][0] = cy * cz * 16384;
		r[0][1] = cy * sz * 16384;
		r[0][2] = -sy * 64'sd268435456;
		r[1][0] = -cx * sz * 16384 + sx * sy * cz;
		r[1][1] = cx * cz * 16384 + sx * sy * sz;
		r[1][2] = sx * cy * 16384;
		r[2][0] = sx * sz * 16384 + cx * sy * cz;
		r[2][1] = -sx * cz * 16384 + cx * sy * sz;
		r[2][2] = cx * cy * 16384;
		for (int i = 0; i < 3; i++) begin
			row.idx = row_t'(i);
			row.c0 = scale_entry(r[i][0], sc[0]);
			row.c1 = scale_entry(r[i][1], sc[1]);
			row.c2 = scale_entry(r[i][2], sc[2]);
			row.c3 = t[i];
			row.last = 1'b0;
			expected_rows.push_back(row);
		end
		row = '{ROW_3, 32'sd0, 32'sd0, 32'sd0, Q16_ONE, 1'b1};
		expected_rows.push_back(row);
	endtask

	function automatic q16_t rand_q16();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return q16_t'($urandom_range(0, 8 * 65536)) - 32'sd262144;
			3: return Q16_ONE;
			default: return q16_t'($urandom);
		endcase
	endfunction

	function automatic angle_t rand_angle();
		if ($urandom_range(0, 3) == 0)
			return angle_t'($urandom);
		return angle_t'($urandom_range(0, 2 * 12868)) - 16'sd12868;
	endfunction

	function automatic matrix_req_t rand_req();
		matrix_req_t m;
		m.tx = q16_t'($urandom);
		m.ty = q16_t'($urandom);
		m.tz = q16_t'($urandom);
		m.ax = rand_angle();
		m.ay = rand_angle();
		m.az = rand_angle();
		m.sx = rand_q16();
		m.sy = rand_q16();
		m.sz = rand_q16();
		return m;
	endfunction

	// mostly short gaps, a few long ones, runs with none
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.translate_x <= '0;
			req.translate_y <= '0;
			req.translate_z <= '0;
			req.angle_x <= '0;
			req.angle_y <= '0;
			req.angle_z <= '0;
			req.scale_x <= '0;
			req.scale_y <= '0;
			req.scale_z <= '0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				predict_matrix({req.translate_x, req.translate_y, req.translate_z,
					req.angle_x, req.angle_y, req.angle_z,
					req.scale_x, req.scale_y, req.scale_z});
				void'(pending_reqs.pop_front());
				send_gap = gap_len();
			end
			if (!(req.valid && !req.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req.valid <= 1'b1;
					{req.translate_x, req.translate_y, req.translate_z,
						req.angle_x, req.angle_y, req.angle_z,
						req.scale_x, req.scale_y, req.scale_z} <= pending_reqs[0];
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall and monitor
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected row %0d", $time, rsp.row_index);
					failed = 1'b1;
				end else begin
					matrix_row_t exp_row, got;
					exp_row = expected_rows.pop_front();
					got = {rsp.row_index, rsp.col0, rsp.col1, rsp.col2, rsp.col3,
						rsp.last_row};
					if (got !== exp_row) begin
						$display("%0t: row mismatch expected idx=%0d %0d %0d %0d %0d last=%0b",
							$time, exp_row.idx, exp_row.c0, exp_row.c1, exp_row.c2,
							exp_row.c3, exp_row.last);
						$display("%0t:                actual idx=%0d %0d %0d %0d %0d last=%0b",
							$time, got.idx, got.c0, got.c1, got.c2, got.c3, got.last);
						failed = 1'b1;
					end
				end
			end
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				recv_gap = gap_len();
			end
		end
	end

	task automatic push_req(input q16_t t, input angle_t ax, input angle_t ay, input angle_t az,
		input q16_t sx, input q16_t sy, input q16_t sz);
		pending_reqs.push_back({t, ~t, t, ax, ay, az, sx, sy, sz});
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_rows.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		failed = 1'b0;
		hold_rsp = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed: identity, field extremes, quadrant edges, wrap, overflow
		push_req(32'sd0, 16'sd0, 16'sd0, 16'sd0, Q16_ONE, Q16_ONE, Q16_ONE);
		push_req(32'sh7fffffff, 16'sh7fff, 16'sh8000, 16'sd0,
			32'sh7fffffff, 32'sh80000000, 32'sd0);
		push_req(32'sh80000000, 16'sh8000, 16'sh7fff, 16'sh7fff,
			32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		push_req(32'sh12345678, 16'sd6434, 16'sd6435, -16'sd6434,
			Q16_ONE, -Q16_ONE, 32'sd131072);
		push_req(32'sd1, 16'sd12868, -16'sd12868, 16'sd12869, Q16_ONE, Q16_ONE, Q16_ONE);
		push_req(-32'sd1, 16'sd25736, 16'sd30000, -16'sd30000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		push_req(32'sh55555555, 16'sh5555, 16'shaaaa, 16'sd3217, -Q16_ONE, Q16_ONE, -Q16_ONE);
		push_req(32'shaaaaaaaa, 16'shaaaa, 16'sh5555, -16'sd3217,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		push_req(32'sd65536, -16'sd1, 16'sd1, 16'sd9651, 32'sd1, -32'sd1, 32'sd0);
		for (int i = 0; i < 8; i++)
			pending_reqs.push_back(rand_req());
		// hold results off long enough to fill the pipe and stall the input
		hold_rsp = 1'b1;
		repeat (LATENCY * 4) @(posedge clk);
		hold_rsp = 1'b0;
		drain();
		for (int i = 0; i < 210; i++) begin
			pending_reqs.push_back(rand_req());
			if (i == 100)
				drain();
		end
		drain();
		repeat (LATENCY * 2) @(posedge clk);
		if (!failed)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

### filelist.f
+incdir+design
design/wmb_pkg.sv
design/wmb_item_if.sv
design/wmb_cordic.sv
design/world_matrix_builder_core.sv
test/tb.sv
